[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppm_pkg.sv]
// types and constants of the peak-to-peak power meter
package ppm_pkg;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_BAND,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_QEST,
    ST_QREM,
    ST_DONE
  } state_t;

  // input request kinds carried on tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_WINDOW = 1'b1;

  // configuration register indexes
  localparam logic [2:0] CFG_VOLT_OFFSET = 3'd0;

  // peak tracker and voltage offset reset values
  localparam logic signed [15:0] PEAK_HIGH_RESET = 16'sd0;
  localparam logic signed [15:0] PEAK_LOW_RESET  = 16'sd9999;
  localparam logic signed [17:0] VOLT_OFFSET_RESET = -18'sd27000;

  // voltage scale 230000/32767 = 7 + 631/32767
  localparam logic [25:0] VOLT_FRAC_NUM = 26'd631;
  localparam logic [18:0] VOLT_INT_MUL  = 19'd7;
  localparam logic [15:0] VOLT_DEN      = 16'd32767;

  // current scale 30000000/65535 = 457 + 50505/65535
  localparam logic [31:0] CUR_FRAC_NUM = 32'd50505;
  localparam logic [24:0] CUR_INT_MUL  = 25'd457;
  localparam logic [16:0] CUR_DEN      = 17'd65535;

  // floors and ceiling
  localparam logic signed [20:0] VOLT_FLOOR_MV = 21'sd2;
  localparam logic signed [20:0] VOLT_MAX_MV   = 21'sd524287;
  localparam logic [24:0]        CUR_FLOOR_UA  = 25'd5000;

  // upper limits of current bands 0 to 5, band 6 takes the rest
  localparam int NUM_BANDS = 7;
  localparam logic [24:0] BAND_LIMIT [6] = '{
    25'd1000000, 25'd5000000, 25'd10000000,
    25'd15000000, 25'd20000000, 25'd25000000
  };
  localparam logic [22:0] BAND_RESET [NUM_BANDS] = '{
    23'd0, 23'd200000, 23'd450000, 23'd700000,
    23'd500000, 23'd1000000, 23'd1200000
  };

  // power divide by one million: floor(2^45/10^6) times the top 25 product bits
  // gives a quotient at most two low, fixed from the low 22 remainder bits
  localparam logic [25:0] POWER_RECIP = 26'd35184372;
  localparam logic [21:0] POWER_DEN   = 22'd1000000;
  localparam logic [21:0] POWER_DEN2  = 22'd2000000;

  // commands from controller to datapath
  typedef struct packed {
    logic sample_en;
    logic win_en;
    logic scale_en;
    logic band_en;
    logic mul_en;
    logic mul_hi;
    logic sum_en;
    logic qest_en;
    logic qrem_en;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

[src/ppm_ctrl.sv]
// controller state machine of the peak-to-peak power meter
module ppm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tuser,
  input  logic              m_tready,
  input  ppm_pkg::status_t  status,
  output logic              s_tready,
  output ppm_pkg::cmd_t     cmd
);
  import ppm_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = !rst;
        cmd.sample_en = s_tvalid && s_tready && (s_tuser == OP_SAMPLE);
        cmd.win_en    = s_tvalid && s_tready && (s_tuser == OP_WINDOW);
        if (cmd.win_en) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale_en = 1'b1;
        state_next   = ST_BAND;
      end
      ST_BAND: begin
        cmd.band_en = 1'b1;
        state_next  = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_en = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_hi = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = ST_QEST;
      end
      ST_QEST: begin
        cmd.qest_en = 1'b1;
        state_next  = ST_QREM;
      end
      ST_QREM: begin
        cmd.qrem_en = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!status.out_full || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/ppm_datapath.sv]
// peak trackers, scaling, band correction and power datapath
module ppm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ppm_pkg::cmd_t     cmd,
  input  logic [31:0]       s_tdata,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [22:0]       cfg_wdata,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [71:0]       m_tdata,
  output ppm_pkg::status_t  status
);
  import ppm_pkg::*;

  // configuration
  logic signed [17:0] volt_off;
  logic [22:0]        cur_off [NUM_BANDS];

  // peaks and spans
  logic signed [15:0] volt_hi;
  logic signed [15:0] volt_lo;
  logic signed [15:0] cur_hi;
  logic signed [15:0] cur_lo;
  logic [15:0]        volt_span;
  logic [15:0]        cur_span;

  // window-end pipeline registers
  logic [18:0] vscaled;
  logic [24:0] ua;
  logic [18:0] vout;
  logic [24:0] iout;
  logic [31:0] pp_lo;
  logic [31:0] pp_hi;
  logic [43:0] pw;
  logic [23:0] q0;
  logic [21:0] rem;

  // output register
  logic [18:0] out_v;
  logic [24:0] out_i;
  logic [23:0] out_p;

  // combinational values
  logic signed [15:0] vs;
  logic signed [15:0] cs;
  logic signed [15:0] volt_hi_n;
  logic signed [15:0] volt_lo_n;
  logic signed [15:0] cur_hi_n;
  logic signed [15:0] cur_lo_n;
  logic signed [16:0] vdiff;
  logic signed [16:0] cdiff;
  logic [25:0]        xv;
  logic [15:0]        rv;
  logic [18:0]        vq;
  logic [31:0]        xc;
  logic [16:0]        rc;
  logic [24:0]        cq;
  logic signed [20:0] vmv;
  logic [18:0]        vout_c;
  logic [2:0]         band;
  logic [24:0]        boff;
  logic [24:0]        iout_c;
  logic [12:0]        mul_b;
  logic [31:0]        mul_p;
  logic [43:0]        prod;
  logic [50:0]        qprod;
  logic [21:0]        qd;
  logic [1:0]         corr;
  logic [23:0]        q_fix;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_off <= VOLT_OFFSET_RESET;
      cur_off  <= BAND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_VOLT_OFFSET: volt_off <= cfg_wdata[17:0];
        default:         cur_off[3'(cfg_addr - 3'd1)] <= cfg_wdata;
      endcase
    end
  end

  // new extremes and spans for a sample
  assign vs = s_tdata[15:0];
  assign cs = s_tdata[31:16];
  always_comb begin
    volt_hi_n = (volt_hi < vs) ? vs : volt_hi;
    volt_lo_n = (volt_lo > vs) ? vs : volt_lo;
    cur_hi_n  = (cur_hi < cs) ? cs : cur_hi;
    cur_lo_n  = (cur_lo > cs) ? cs : cur_lo;
    vdiff     = {volt_hi_n[15], volt_hi_n} - {volt_lo_n[15], volt_lo_n};
    cdiff     = {cur_hi_n[15], cur_hi_n} - {cur_lo_n[15], cur_lo_n};
  end

  // peak trackers, cleared at window end, spans kept
  always_ff @(posedge clk) begin
    if (rst) begin
      volt_hi   <= PEAK_HIGH_RESET;
      volt_lo   <= PEAK_LOW_RESET;
      cur_hi    <= PEAK_HIGH_RESET;
      cur_lo    <= PEAK_LOW_RESET;
      volt_span <= '0;
      cur_span  <= '0;
    end else if (cmd.sample_en) begin
      volt_hi   <= volt_hi_n;
      volt_lo   <= volt_lo_n;
      cur_hi    <= cur_hi_n;
      cur_lo    <= cur_lo_n;
      volt_span <= vdiff[15:0];
      cur_span  <= cdiff[15:0];
    end else if (cmd.win_en) begin
      volt_hi <= PEAK_HIGH_RESET;
      volt_lo <= PEAK_LOW_RESET;
      cur_hi  <= PEAK_HIGH_RESET;
      cur_lo  <= PEAK_LOW_RESET;
    end
  end

  // span scaling: integer part times span plus a corrected 2^n-1 divide
  always_comb begin
    xv = 26'(volt_span) * VOLT_FRAC_NUM;
    rv = 16'(xv[14:0]) + 16'(xv[25:15]);
    vq = 19'(volt_span) * VOLT_INT_MUL + 19'(xv[25:15])
         + {18'd0, (rv >= VOLT_DEN)};
    xc = 32'(cur_span) * CUR_FRAC_NUM;
    rc = 17'(xc[15:0]) + 17'(xc[31:16]);
    cq = 25'(cur_span) * CUR_INT_MUL + 25'(xc[31:16])
         + {24'd0, (rc >= CUR_DEN)};
  end

  // voltage offset and clamp
  always_comb begin
    vmv = $signed({2'b00, vscaled}) + {{3{volt_off[17]}}, volt_off};
    if (vmv < VOLT_FLOOR_MV) begin
      vout_c = '0;
    end else if (vmv > VOLT_MAX_MV) begin
      vout_c = VOLT_MAX_MV[18:0];
    end else begin
      vout_c = vmv[18:0];
    end
  end

  // current band select, lowest band whose limit is not exceeded
  always_comb begin
    band = 3'(NUM_BANDS - 1);
    for (int k = NUM_BANDS - 2; k >= 0; k--) begin
      if (ua <= BAND_LIMIT[k]) begin
        band = 3'(k);
      end
    end
    boff = {2'b00, cur_off[band]};
    if (ua < CUR_FLOOR_UA) begin
      iout_c = '0;
    end else if (ua > boff) begin
      iout_c = ua - boff;
    end else begin
      iout_c = '0;
    end
  end

  // shared multiplier over two halves of the current
  assign mul_b = cmd.mul_hi ? {1'b0, iout[24:13]} : iout[12:0];
  assign mul_p = 32'(vout) * 32'(mul_b);
  assign prod  = {pp_hi[30:0], 13'd0} + {12'd0, pp_lo};

  // divide by one million: reciprocal estimate, remainder, then up to two steps up
  assign qprod = 51'(pw[43:19]) * 51'(POWER_RECIP);
  assign qd    = q0[21:0] * POWER_DEN;
  always_comb begin
    corr = 2'd0;
    if (rem >= POWER_DEN2) begin
      corr = 2'd2;
    end else if (rem >= POWER_DEN) begin
      corr = 2'd1;
    end
    q_fix = q0 + {22'd0, corr};
  end

  // window-end pipeline
  always_ff @(posedge clk) begin
    if (cmd.scale_en) begin
      vscaled <= vq;
      ua      <= cq;
    end
    if (cmd.band_en) begin
      vout <= vout_c;
      iout <= iout_c;
    end
    if (cmd.mul_en && !cmd.mul_hi) begin
      pp_lo <= mul_p;
    end
    if (cmd.mul_en && cmd.mul_hi) begin
      pp_hi <= mul_p;
    end
    if (cmd.sum_en) begin
      pw <= prod;
    end
    if (cmd.qest_en) begin
      q0 <= qprod[49:26];
    end
    if (cmd.qrem_en) begin
      rem <= pw[21:0] - qd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_v <= vout;
      out_i <= iout;
      out_p <= q_fix;
    end
  end

  assign m_tdata         = {4'd0, out_p, out_i, out_v};
  assign status.out_full = m_tvalid;

endmodule

[src/peak_to_peak_power_meter.sv]
// top level of the peak-to-peak power meter
// a sample request leaves the input ready, so the next request is taken in the following cycle
// a window-end request has its result registered at the output after scaling, band
// correction, two multiplier passes, an add, a reciprocal multiply and a remainder step
// the input is free again once the result is loaded, which a held result can stall
// reset restores offsets to defaults, peaks to 0 and 9999, spans to 0, output empty
module peak_to_peak_power_meter (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // volt_sample[15:0], cur_sample[31:16]
  input  logic        s_tuser,   // operation[0]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // voltage_mv[18:0], current_ua[43:19], power_mw[67:44]
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [22:0] cfg_wdata
);
  import ppm_pkg::*;

  cmd_t    cmd;
  status_t status;

  ppm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  ppm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .status    (status)
  );

endmodule

[src/ppm_checker.sv]
// port-level checks of the peak-to-peak power meter and their bind
`include "assert_macros.svh"

module ppm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // a window end keeps the block busy for the next cycle
  `PPM_ASSERT_NXT(a_win_busy, s_tvalid && s_tready && s_tuser, !s_tready, "window end not busy")

  // a sample leaves the input ready in the next cycle
  `PPM_ASSERT_NXT(a_sample_one, s_tvalid && s_tready && !s_tuser, s_tready, "sample stalled")

  // stalled result stays valid and unchanged
  `PPM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

  // zero voltage or zero current gives zero power
  `PPM_ASSERT_IMP(a_zero_power, m_tvalid && (m_tdata[18:0] == 19'd0 || m_tdata[43:19] == 25'd0), m_tdata[67:44] == 24'd0, "power not zero")

endmodule

bind peak_to_peak_power_meter ppm_checker u_ppm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
